### rtl/wbts_pkg.sv
// Shared types and constants of the well buffer trace solver.
`timescale 1ns / 1ps
`default_nettype none
package wbts_pkg;

  localparam int RADIX_STEPS = 4;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_TAU   = 2'd1;
  localparam logic [1:0] CFG_RATIO = 2'd2;

  localparam logic [1:0] MODE_TOTAL = 2'd0;
  localparam logic [1:0] MODE_BKG   = 2'd1;
  localparam logic [1:0] MODE_HIW   = 2'd2;

  localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    MUL_B,
    MUL_DV,
    MUL_TR
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_AVAL,
    DIV_ITAU,
    DIV_DVN
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    logic     mul_wb;
    mul_sel_t mul_sel;
    logic     div_go;
    logic     div_wb;
    div_sel_t div_sel;
    logic     num_go;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/wbts_div.sv
// Iterative restoring divider, several quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wbts_div #(
  parameter int DVW = 64,
  parameter int DSW = 33
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                busy,
  output logic [DVW-1:0]      quotient
);
  import wbts_pkg::*;

  localparam int ITER = DVW / RADIX_STEPS;
  localparam int CW   = $clog2(ITER + 1);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [DSW-1:0] rem_r, rem_nxt, den_r;
  logic [DVW-1:0] quo_r, quo_nxt;
  logic [DSW:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < RADIX_STEPS; i++) begin
      trial   = {rem_nxt, quo_nxt[DVW-1]};
      quo_nxt = {quo_nxt[DVW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial      = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DSW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(ITER);
      rem_r  <= '0;
      quo_r  <= dividend;
      den_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/wbts_datapath.sv
// Datapath: registers, shared multiplier, shared divider and clipping.
`timescale 1ns / 1ps
`default_nettype none
module wbts_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wbts_pkg::cmd_t   cmd,
  output wbts_pkg::status_t     status,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire logic [95:0]      in_tdata,
  input  wire logic             in_tuser,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tuser
);
  import wbts_pkg::*;

  localparam int DVW = ((48 + FRAC_BITS + RADIX_STEPS - 1) / RADIX_STEPS) * RADIX_STEPS;
  localparam int DSW = 33;
  localparam logic [32:0] ONE = 33'(1) << FRAC_BITS;

  logic [1:0]         mode_r, mode_eff;
  logic [31:0]        tau_r, tau_eff;
  logic signed [31:0] ratio_r;
  logic signed [31:0] rh_r, bh_r, dv_r, dvn_r, rh_eff;
  logic [31:0]        dt_r, aval_r;
  logic signed [47:0] int_r, bterm_r, dvterm_r, itau_r, num_r;
  logic               sat_r;
  logic [64:0]        prod_r, prod_nxt, shifted;
  logic               out_valid_r, out_sat_r;
  logic [31:0]        out_data_r;

  logic signed [32:0] rm1, dvs;
  logic [32:0]        rm1_mag, dvs_mag, mul_a;
  logic [31:0]        bh_mag, dv_mag, mul_b;
  logic               mul_neg, mul_over;
  logic [47:0]        mul_mag;
  logic signed [47:0] mul_res;

  logic [DVW-1:0]     div_dnd, quo;
  logic [DSW-1:0]     div_dsr;
  logic               div_busy;
  logic [47:0]        int_mag, num_mag, fd_mag;
  logic               aval_over, fd_over, fd_neg;
  logic signed [47:0] fd_val;
  logic               dvn_hi, dvn_lo;

  logic signed [50:0] num_sum;
  logic               num_hi, num_lo;
  logic signed [48:0] int_sum;
  logic               int_hi, int_lo;
  logic signed [47:0] int_clip;
  logic signed [32:0] res_sum;
  logic               res_hi, res_lo;
  logic [31:0]        res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TOTAL;
      tau_r   <= 32'(1) << FRAC_BITS;
      ratio_r <= 32'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_TAU:   tau_r   <= cfg_data;
        CFG_RATIO: ratio_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mode_eff = (mode_r == MODE_BKG || mode_r == MODE_HIW) ? mode_r : MODE_TOTAL;
  assign tau_eff  = (tau_r == 32'd0) ? 32'd1 : tau_r;
  assign rh_eff   = (mode_eff == MODE_BKG) ? 32'sd0 : rh_r;

  assign rm1     = 33'(ratio_r) - $signed(ONE);
  assign rm1_mag = rm1[32] ? 33'(-rm1) : 33'(rm1);
  assign bh_mag  = bh_r[31] ? 32'(-bh_r) : 32'(bh_r);
  assign dv_mag  = dv_r[31] ? 32'(-dv_r) : 32'(dv_r);
  assign dvs     = 33'(dv_r) + 33'(dvn_r);
  assign dvs_mag = dvs[32] ? 33'(-dvs) : 33'(dvs);

  always_comb begin
    case (cmd.mul_sel)
      MUL_DV: begin
        mul_a   = {1'b0, dv_mag};
        mul_b   = aval_r;
        mul_neg = dv_r[31];
      end
      MUL_TR: begin
        mul_a   = dvs_mag;
        mul_b   = dt_r;
        mul_neg = dvs[32];
      end
      default: begin
        mul_a   = rm1_mag;
        mul_b   = bh_mag;
        mul_neg = rm1[32] ^ bh_r[31];
      end
    endcase
  end

  assign prod_nxt = 65'(mul_a) * 65'(mul_b);
  assign shifted  = (cmd.mul_sel == MUL_TR) ? (prod_r >> (FRAC_BITS + 1))
                                            : (prod_r >> FRAC_BITS);
  assign mul_over = shifted > 65'(LIM48);
  assign mul_mag  = mul_over ? LIM48 : shifted[47:0];
  assign mul_res  = mul_neg ? $signed(48'(-mul_mag)) : $signed(mul_mag);

  assign int_mag = int_r[47] ? 48'(-int_r) : 48'(int_r);
  assign num_mag = num_r[47] ? 48'(-num_r) : 48'(num_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_ITAU: begin
        div_dnd = DVW'(int_mag) << FRAC_BITS;
        div_dsr = {1'b0, tau_eff};
      end
      DIV_DVN: begin
        div_dnd = DVW'(num_mag) << FRAC_BITS;
        div_dsr = {1'b0, aval_r} + ONE;
      end
      default: begin
        div_dnd = DVW'(dt_r) << FRAC_BITS;
        div_dsr = {tau_eff, 1'b0};
      end
    endcase
  end

  wbts_div #(
    .DVW(DVW),
    .DSW(DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign aval_over = |quo[DVW-1:32];
  assign fd_over   = |quo[DVW-1:47];
  assign fd_mag    = fd_over ? LIM48 : quo[47:0];
  assign fd_neg    = (cmd.div_sel == DIV_ITAU) ? int_r[47] : num_r[47];
  assign fd_val    = fd_neg ? $signed(48'(-fd_mag)) : $signed(fd_mag);
  assign dvn_hi    = fd_val > 48'sd2147483647;
  assign dvn_lo    = fd_val < -48'sd2147483648;

  assign num_sum = 51'(rh_eff) + 51'(bterm_r) - 51'(itau_r) - 51'(dvterm_r);
  assign num_hi  = num_sum > $signed(51'(LIM48));
  assign num_lo  = num_sum < -$signed(51'(LIM48));

  assign int_sum  = 49'(int_r) + 49'(mul_res);
  assign int_hi   = int_sum > $signed(49'(LIM48));
  assign int_lo   = int_sum < -$signed(49'(LIM48));
  assign int_clip = int_hi ? $signed(LIM48) :
                    int_lo ? $signed(48'(-LIM48)) : int_sum[47:0];

  assign res_sum = 33'(dvn_r) + 33'(bh_r);
  assign res_hi  = (mode_eff != MODE_HIW) && (res_sum > 33'sd2147483647);
  assign res_lo  = (mode_eff != MODE_HIW) && (res_sum < -33'sd2147483648);
  assign res_val = (mode_eff == MODE_HIW) ? dvn_r :
                   res_hi ? 32'h7FFF_FFFF :
                   res_lo ? 32'h8000_0000 : res_sum[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      int_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        rh_r  <= in_tdata[31:0];
        bh_r  <= in_tdata[63:32];
        dt_r  <= in_tdata[95:64];
        sat_r <= 1'b0;
        if (in_tuser) begin
          dv_r  <= '0;
          int_r <= '0;
        end
      end
      if (cmd.mul_go) begin
        prod_r <= prod_nxt;
      end
      if (cmd.mul_wb) begin
        case (cmd.mul_sel)
          MUL_B: begin
            if (mode_eff == MODE_HIW) begin
              bterm_r <= '0;
            end else begin
              bterm_r <= mul_res;
              sat_r   <= sat_r | mul_over;
            end
          end
          MUL_DV: begin
            dvterm_r <= mul_res;
            sat_r    <= sat_r | mul_over;
          end
          default: ;
        endcase
      end
      if (cmd.div_wb) begin
        case (cmd.div_sel)
          DIV_AVAL: begin
            aval_r <= aval_over ? 32'hFFFF_FFFF : quo[31:0];
            sat_r  <= sat_r | aval_over;
          end
          DIV_ITAU: begin
            itau_r <= fd_val;
            sat_r  <= sat_r | fd_over;
          end
          default: begin
            dvn_r <= dvn_hi ? 32'sh7FFF_FFFF :
                     dvn_lo ? 32'sh8000_0000 : fd_val[31:0];
            sat_r <= sat_r | fd_over | dvn_hi | dvn_lo;
          end
        endcase
      end
      if (cmd.num_go) begin
        num_r <= num_hi ? $signed(LIM48) :
                 num_lo ? $signed(48'(-LIM48)) : num_sum[47:0];
        sat_r <= sat_r | num_hi | num_lo;
      end
      if (cmd.finish) begin
        dv_r       <= dvn_r;
        int_r      <= int_clip;
        out_data_r <= res_val;
        out_sat_r  <= sat_r | mul_over | int_hi | int_lo | res_hi | res_lo;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule
`default_nettype wire

### rtl/wbts_ctrl.sv
// Controller: sequences one frame through multiplier, divider and update.
`timescale 1ns / 1ps
`default_nettype none
module wbts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire wbts_pkg::status_t status,
  output wbts_pkg::cmd_t         cmd
);
  import wbts_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BMUL, ST_BWB, ST_ASTART, ST_AWAIT, ST_AWB,
    ST_DVMUL, ST_DVWB, ST_ISTART, ST_IWAIT, ST_IWB, ST_NUM,
    ST_DSTART, ST_DWAIT, ST_DWB, ST_TMUL, ST_FIN
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE:   if (in_tvalid) state_r <= ST_BMUL;
        ST_BMUL:   state_r <= ST_BWB;
        ST_BWB:    state_r <= ST_ASTART;
        ST_ASTART: state_r <= ST_AWAIT;
        ST_AWAIT:  if (!status.div_busy) state_r <= ST_AWB;
        ST_AWB:    state_r <= ST_DVMUL;
        ST_DVMUL:  state_r <= ST_DVWB;
        ST_DVWB:   state_r <= ST_ISTART;
        ST_ISTART: state_r <= ST_IWAIT;
        ST_IWAIT:  if (!status.div_busy) state_r <= ST_IWB;
        ST_IWB:    state_r <= ST_NUM;
        ST_NUM:    state_r <= ST_DSTART;
        ST_DSTART: state_r <= ST_DWAIT;
        ST_DWAIT:  if (!status.div_busy) state_r <= ST_DWB;
        ST_DWB:    state_r <= ST_TMUL;
        ST_TMUL:   state_r <= ST_FIN;
        ST_FIN:    if (status.out_free) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_B;
    cmd.div_sel = DIV_AVAL;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_tvalid;
      ST_BMUL:   cmd.mul_go = 1'b1;
      ST_BWB:    cmd.mul_wb = 1'b1;
      ST_ASTART: cmd.div_go = 1'b1;
      ST_AWB:    cmd.div_wb = 1'b1;
      ST_DVMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_DV;
      end
      ST_DVWB: begin
        cmd.mul_wb  = 1'b1;
        cmd.mul_sel = MUL_DV;
      end
      ST_ISTART: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_ITAU;
      end
      ST_IWAIT:  cmd.div_sel = DIV_ITAU;
      ST_IWB: begin
        cmd.div_wb  = 1'b1;
        cmd.div_sel = DIV_ITAU;
      end
      ST_NUM:    cmd.num_go = 1'b1;
      ST_DSTART: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_DVN;
      end
      ST_DWAIT:  cmd.div_sel = DIV_DVN;
      ST_DWB: begin
        cmd.div_wb  = 1'b1;
        cmd.div_sel = DIV_DVN;
      end
      ST_TMUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_TR;
      end
      ST_FIN: begin
        cmd.finish  = status.out_free;
        cmd.mul_sel = MUL_TR;
      end
      default: ;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

### rtl/well_buffer_trace_solver.sv
// Top level of the well buffer trace solver.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: red_sample, blue_sample, frame_step; tuser: first_frame
//   out_     master     tdata: trace_value; tuser: saturated
//   cfg_     write      index 0 solve_mode, 1 buffer_tau, 2 buffer_ratio
//
// The time from one accepted transaction to the next is set by three dependent divisions
// on the shared divider, which retires four quotient bits per cycle, unless the output
// holds the last step. Reset sets the configuration registers to their defaults and
// clears the solver state. A result waits in the output register; the next
// transaction is accepted meanwhile, and the last step of the following frame
// holds until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module well_buffer_trace_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // red_sample, blue_sample, frame_step
  input  wire logic        in_tuser,   // first_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // trace_value
  output logic             out_tuser   // saturated
);
  import wbts_pkg::*;

  cmd_t    cmd;
  status_t status;

  wbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wbts_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("controller stayed idle after an input transaction");

  a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_busy |-> !in_tready)
    else $error("divider busy while the controller is idle");

  a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(!in_tready))
    else $error("result appeared without a frame in progress");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_tvalid || out_tready)
    else $error("result written over one not yet taken");

endmodule
`default_nettype wire

### test/well_buffer_trace_solver_tb.sv
// Self-checking testbench for the well buffer trace solver with a built-in fixed-point predictor.
`timescale 1ns / 1ps
module well_buffer_trace_solver_tb;
  import wbts_pkg::*;

  localparam int          FRAC      = 16;
  localparam longint      CLIP48    = 64'h7FFF_FFFF_FFFF;
  localparam longint      MAX_S32   = 64'h7FFF_FFFF;
  localparam longint      MIN_S32   = -64'h8000_0000;
  localparam int          MAX_CYCLES = 1000000;

  typedef struct {
    logic [31:0] red;
    logic [31:0] blue;
    logic [31:0] step;
    logic        first;
  } frame_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } trace_t;

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  frame_t frame_q[$];
  trace_t trace_q[$];
  frame_t cur_frame;

  logic [1:0]  mode_reg;
  logic [31:0] tau_reg;
  logic [31:0] ratio_reg;
  longint      dv_state;
  longint      integ_state;
  bit          clip_hit;

  int errors;
  int cycles;
  int burst_left;
  int gap_left;
  int stall_style;

  well_buffer_trace_solver dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic longint unsigned umag(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      clip_hit = 1;
      return hi;
    end
    if (v < lo) begin
      clip_hit = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint scale_mul(longint a, longint unsigned b, int sh);
    longint unsigned m;
    longint r;
    m = (umag(a) * b) >> sh;
    r = (m > longint'(CLIP48)) ? CLIP48 + 1 : longint'(m);
    r = clamp(r, 0, CLIP48);
    return a < 0 ? -r : r;
  endfunction

  function automatic longint frac_div(longint num, longint unsigned den);
    longint unsigned m, q, r, v;
    longint res;
    m = umag(num);
    q = m / den;
    r = m % den;
    if (q > (longint'(CLIP48) >> FRAC)) begin
      clip_hit = 1;
      res = CLIP48;
    end else begin
      v = (q << FRAC) + ((r << FRAC) / den);
      if (v > longint'(CLIP48)) begin
        clip_hit = 1;
        v = CLIP48;
      end
      res = longint'(v);
    end
    return num < 0 ? -res : res;
  endfunction

  function automatic void solve_frame(frame_t f);
    longint rh, bh, bterm, itau, dvterm, num, dvn, res;
    longint unsigned dt, tau, aval;
    longint one;
    logic [1:0] mode;
    trace_t t;
    one = longint'(1) << FRAC;
    rh = longint'($signed(f.red));
    bh = longint'($signed(f.blue));
    dt = longint'(f.step);
    mode = (mode_reg == MODE_BKG || mode_reg == MODE_HIW) ? mode_reg : MODE_TOTAL;
    tau = (tau_reg == 0) ? 1 : longint'(tau_reg);
    bterm = 0;
    clip_hit = 0;
    if (f.first) begin
      dv_state = 0;
      integ_state = 0;
    end
    if (mode == MODE_BKG) rh = 0;
    if (mode != MODE_HIW)
      bterm = scale_mul(longint'($signed(ratio_reg)) - one, umag(bh), FRAC) * (bh < 0 ? -1 : 1);
    aval = (dt << FRAC) / (2 * tau);
    if (aval > 64'hFFFF_FFFF) begin
      clip_hit = 1;
      aval = 64'hFFFF_FFFF;
    end
    itau = frac_div(integ_state, tau);
    dvterm = scale_mul(dv_state, aval, FRAC);
    num = clamp(rh + bterm - itau - dvterm, -CLIP48, CLIP48);
    dvn = clamp(frac_div(num, longint'(one) + aval), MIN_S32, MAX_S32);
    integ_state = clamp(integ_state + scale_mul(dv_state + dvn, dt, FRAC + 1),
                        -CLIP48, CLIP48);
    dv_state = dvn;
    res = (mode == MODE_HIW) ? dv_state : clamp(dv_state + bh, MIN_S32, MAX_S32);
    t.value = res[31:0];
    t.sat = clip_hit;
    trace_q.push_back(t);
  endfunction

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        solve_frame(cur_frame);
        nv = 0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (frame_q.size() > 0) begin
          cur_frame = frame_q.pop_front();
          in_tdata <= {cur_frame.step, cur_frame.blue, cur_frame.red};
          in_tuser <= cur_frame.first;
          nv = 1;
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      in_tvalid <= nv;
    end
  end

  // Receiver: out_tready follows one of four stall styles, picked anew at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (cycles % 256 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0: out_tready <= 1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ((cycles / 40) % 2 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    trace_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (trace_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: value %h sat %b", out_tdata, out_tuser);
      end else begin
        e = trace_q.pop_front();
        if (out_tdata !== e.value || out_tuser !== e.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: value exp %h got %h, sat exp %b got %b",
                     e.value, out_tdata, e.sat, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MODE: mode_reg = val[1:0];
      CFG_TAU: tau_reg = val;
      default: ratio_reg = val;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_idle();
    while (frame_q.size() != 0 || in_tvalid || trace_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 0;
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  function automatic void add_frame(logic [31:0] r, logic [31:0] b, logic [31:0] s, logic f);
    frame_t fr;
    fr.red = r;
    fr.blue = b;
    fr.step = s;
    fr.first = f;
    frame_q.push_back(fr);
  endfunction

  function automatic void add_traces(int n);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_frame($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        if (left == 0) left = $urandom_range(1, 30);
        add_frame(pick_sample(), pick_sample(), pick_step(), left == 1 || i == 0);
        left--;
      end
    end
  endfunction

  initial begin
    logic [31:0] tau_pick[4];
    logic [31:0] ratio_pick[4];
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    errors = 0;
    cycles = 0;
    stall_style = 0;
    mode_reg = MODE_TOTAL;
    tau_reg = 32'h0001_0000;
    ratio_reg = 32'h0001_0000;
    dv_state = 0;
    integ_state = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    add_frame(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 1);
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 0);
    add_frame(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 0);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    add_frame(0, 0, 0, 1);
    add_frame(32'hFFFF_FFFF, 32'h0000_0001, 0, 0);
    add_frame(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 1);
    add_frame(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 0);
    add_frame(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 0);
    wait_idle();
    write_reg(CFG_RATIO, 32'h7FFF_FFFF);
    write_reg(CFG_TAU, 32'h0000_0001);
    add_frame(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    add_frame(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    add_frame(32'h7FFF_FFFF, 32'h1234_5678, 32'h0001_0000, 0);
    wait_idle();
    write_reg(CFG_TAU, 32'h0000_0000);
    write_reg(CFG_RATIO, 32'h8000_0000);
    add_frame(32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0100, 1);
    add_frame(32'h0001_0000, 32'h8000_0000, 32'h0000_0100, 0);
    wait_idle();
    write_reg(CFG_TAU, 32'hFFFF_FFFF);
    write_reg(CFG_MODE, 32'(MODE_BKG));
    add_frame(32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1);
    wait_idle();
    write_reg(CFG_MODE, 32'(MODE_HIW));
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
    wait_idle();
    write_reg(CFG_MODE, 32'd3);
    add_frame(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
    add_frame(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    wait_idle();

    tau_pick = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000};
    ratio_pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000};
    for (int p = 0; p < 12; p++) begin
      write_reg(CFG_MODE, $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_TAU, tau_pick[$urandom_range(0, 3)]);
        1: write_reg(CFG_TAU, $urandom);
        default: write_reg(CFG_TAU, $urandom_range(32'h0000_4000, 32'h0010_0000));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_RATIO, ratio_pick[$urandom_range(0, 3)]);
        1: write_reg(CFG_RATIO, $urandom);
        default: write_reg(CFG_RATIO, $urandom_range(0, 32'h0004_0000));
      endcase
      add_traces(60);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
